// ===== rtl/core/itp_pkg.sv =====
// Package of shared types, character codes and classification functions for the converter.
package itp_pkg;

    localparam int unsigned MAX_LEN = 64;
    localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
    localparam int unsigned CNT_W   = ADDR_W + 1;

    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLASSIFY,
        ST_OPERATOR,
        ST_PAREN,
        ST_POP_WAIT,
        ST_FLUSH,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    function automatic logic is_operand(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == C_PLUS) || (c == C_MINUS) || (c == C_STAR) ||
               (c == C_SLASH) || (c == C_CARET);
    endfunction

    // Zero stands for anything that is not an operator.
    function automatic logic [1:0] op_rank(input logic [7:0] c);
        logic [1:0] rank;
        rank = 2'd0;
        if (c == C_CARET) begin
            rank = 2'd3;
        end else if ((c == C_STAR) || (c == C_SLASH)) begin
            rank = 2'd2;
        end else if ((c == C_PLUS) || (c == C_MINUS)) begin
            rank = 2'd1;
        end
        return rank;
    endfunction

endpackage

// ===== rtl/core/infix_to_prefix_converter_top.sv =====
// Infix to prefix converter: text, operator stack and output held in on-chip memories.
//
// An infix expression is loaded one character per transaction: a character is
// taken at a rising edge where start is high and busy is low, and i_in_last
// marks the final one. Loading takes one character per cycle; characters
// beyond 64 are dropped and reported on o_out_truncated.
// After the final character busy rises while the text is scanned from its end
// with an operator stack. An operand or an ignored character passes a memory
// read, then classification; an operator or an opening parenthesis gets a
// further step to push or to finish, and dropping a matched closing
// parenthesis one more for the stack read of the new top. Each entry moved
// from the stack to the output takes a pop, then a stack memory read of the
// new top. The remaining stack is flushed in the same way, entry by entry,
// followed by a closing step.
// The prefix result is then read back in reverse from the output memory; each
// result transaction follows its own memory read and is shown for a single
// cycle with o_valid high; o_out_last marks the final one. An empty result
// gives one transaction with o_out_empty set and o_out_char zero. The
// receiver cannot stall, so results are never held back. Each memory has a
// single read port.
// Synchronous reset returns the block to idle with empty text, stack and
// output; memory contents are not cleared and need no clearing pass.
module infix_to_prefix_converter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    output logic       o_out_empty,
    output logic       o_out_truncated
);

    localparam int unsigned AW = itp_pkg::ADDR_W;
    localparam int unsigned CW = itp_pkg::CNT_W;

    logic [7:0] r_text  [itp_pkg::MAX_LEN];
    logic [7:0] r_stack [itp_pkg::MAX_LEN];
    logic [7:0] r_outbuf[itp_pkg::MAX_LEN];

    itp_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_olen, n_olen;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_top, n_top;
    logic [7:0]    r_c, n_c;

    logic [7:0]    r_text_rd, r_stack_rd, r_out_rd;

    logic          r_o_valid, n_o_valid;
    logic [7:0]    r_o_char, n_o_char;
    logic          r_o_last, n_o_last;
    logic          r_o_empty, n_o_empty;
    logic          r_o_trunc, n_o_trunc;

    logic          text_we, stack_we, out_we;
    logic [AW-1:0] text_raddr, stack_waddr, stack_raddr, out_waddr, out_raddr;
    logic [7:0]    stack_wdata, out_wdata;

    always_ff @(posedge i_clk) begin
        if (text_we) begin
            r_text[r_len[AW-1:0]] <= i_in_char;
        end
        r_text_rd <= r_text[text_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[stack_waddr] <= stack_wdata;
        end
        r_stack_rd <= r_stack[stack_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_outbuf[out_waddr] <= out_wdata;
        end
        r_out_rd <= r_outbuf[out_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= itp_pkg::ST_IDLE;
            r_ret     <= itp_pkg::ST_IDLE;
            r_len     <= '0;
            r_idx     <= '0;
            r_depth   <= '0;
            r_olen    <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_depth   <= n_depth;
            r_olen    <= n_olen;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_c       <= n_c;
        r_o_char  <= n_o_char;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_trunc <= n_o_trunc;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_len     = r_len;
        n_idx     = r_idx;
        n_depth   = r_depth;
        n_olen    = r_olen;
        n_ovf     = r_ovf;
        n_top     = r_top;
        n_c       = r_c;
        n_o_valid = 1'b0;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        n_o_empty = r_o_empty;
        n_o_trunc = r_o_trunc;

        text_we     = 1'b0;
        text_raddr  = r_idx[AW-1:0];
        stack_we    = 1'b0;
        stack_waddr = r_depth[AW-1:0];
        stack_wdata = r_c;
        stack_raddr = r_depth[AW-1:0] - AW'(2);
        out_we      = 1'b0;
        out_waddr   = r_olen[AW-1:0];
        out_wdata   = r_top;
        out_raddr   = r_olen[AW-1:0] - AW'(1);

        case (r_state)
            itp_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_len < CW'(itp_pkg::MAX_LEN)) begin
                        text_we = 1'b1;
                        n_len   = r_len + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_idx   = n_len;
                        n_state = itp_pkg::ST_SCAN;
                    end
                end
            end

            itp_pkg::ST_SCAN: begin
                if (r_idx == '0) begin
                    n_state = itp_pkg::ST_FLUSH;
                end else begin
                    text_raddr = r_idx[AW-1:0] - AW'(1);
                    n_idx      = r_idx - CW'(1);
                    n_state    = itp_pkg::ST_CLASSIFY;
                end
            end

            itp_pkg::ST_CLASSIFY: begin
                n_c     = r_text_rd;
                n_state = itp_pkg::ST_SCAN;
                if (itp_pkg::is_operand(r_text_rd)) begin
                    out_we    = 1'b1;
                    out_wdata = r_text_rd;
                    n_olen    = r_olen + CW'(1);
                end else if (r_text_rd == itp_pkg::C_RPAREN) begin
                    stack_we    = 1'b1;
                    stack_wdata = r_text_rd;
                    n_top       = r_text_rd;
                    n_depth     = r_depth + CW'(1);
                end else if (r_text_rd == itp_pkg::C_LPAREN) begin
                    n_state = itp_pkg::ST_PAREN;
                end else if (itp_pkg::is_operator(r_text_rd)) begin
                    n_state = itp_pkg::ST_OPERATOR;
                end
            end

            itp_pkg::ST_OPERATOR: begin
                if ((r_depth != '0) && (itp_pkg::op_rank(r_top) > itp_pkg::op_rank(r_c))) begin
                    out_we  = 1'b1;
                    n_olen  = r_olen + CW'(1);
                    n_depth = r_depth - CW'(1);
                    n_ret   = itp_pkg::ST_OPERATOR;
                    n_state = itp_pkg::ST_POP_WAIT;
                end else begin
                    stack_we = 1'b1;
                    n_top    = r_c;
                    n_depth  = r_depth + CW'(1);
                    n_state  = itp_pkg::ST_SCAN;
                end
            end

            itp_pkg::ST_PAREN: begin
                if (r_depth == '0) begin
                    n_state = itp_pkg::ST_SCAN;
                end else if (r_top != itp_pkg::C_RPAREN) begin
                    out_we  = 1'b1;
                    n_olen  = r_olen + CW'(1);
                    n_depth = r_depth - CW'(1);
                    n_ret   = itp_pkg::ST_PAREN;
                    n_state = itp_pkg::ST_POP_WAIT;
                end else begin
                    // The matching closing parenthesis is dropped.
                    n_depth = r_depth - CW'(1);
                    n_ret   = itp_pkg::ST_SCAN;
                    n_state = itp_pkg::ST_POP_WAIT;
                end
            end

            itp_pkg::ST_POP_WAIT: begin
                // The entry below the popped one becomes the cached top.
                n_top   = r_stack_rd;
                n_state = r_ret;
            end

            itp_pkg::ST_FLUSH: begin
                if (r_depth != '0) begin
                    out_we  = 1'b1;
                    n_olen  = r_olen + CW'(1);
                    n_depth = r_depth - CW'(1);
                    n_ret   = itp_pkg::ST_FLUSH;
                    n_state = itp_pkg::ST_POP_WAIT;
                end else if (r_olen == '0) begin
                    n_o_valid = 1'b1;
                    n_o_char  = 8'h00;
                    n_o_last  = 1'b1;
                    n_o_empty = 1'b1;
                    n_o_trunc = r_ovf;
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    n_state   = itp_pkg::ST_IDLE;
                end else begin
                    n_state = itp_pkg::ST_EMIT_RD;
                end
            end

            itp_pkg::ST_EMIT_RD: begin
                n_olen  = r_olen - CW'(1);
                n_state = itp_pkg::ST_EMIT_WR;
            end

            itp_pkg::ST_EMIT_WR: begin
                n_o_valid = 1'b1;
                n_o_char  = r_out_rd;
                n_o_last  = (r_olen == '0);
                n_o_empty = 1'b0;
                n_o_trunc = r_ovf;
                if (r_olen == '0) begin
                    n_len   = '0;
                    n_depth = '0;
                    n_ovf   = 1'b0;
                    n_state = itp_pkg::ST_IDLE;
                end else begin
                    n_state = itp_pkg::ST_EMIT_RD;
                end
            end

            default: begin
                n_state = itp_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != itp_pkg::ST_IDLE);
    assign o_valid         = r_o_valid;
    assign o_out_char      = r_o_char;
    assign o_out_last      = r_o_last;
    assign o_out_empty     = r_o_empty;
    assign o_out_truncated = r_o_trunc;

endmodule
